// ----- hdl/cse_pkg.sv -----
`default_nettype none

package cse_pkg;

  // datapath widths
  localparam int X_W    = 16;  // |angle|
  localparam int S_W    = 31;  // x^2, unsigned Q5.26
  localparam int R_W    = 32;  // reciprocal, unsigned Q0.32
  localparam int T_W    = 30;  // s*r rounded, unsigned Q.26
  localparam int ACC_W  = 34;  // accumulator, signed Q.26
  localparam int MA_W   = 35;  // multiplier operand a (signed)
  localparam int PROD_W = 68;  // multiplier product (signed)
  localparam int IDX_W  = 5;   // series index
  localparam int OUT_W  = 18;  // cosine, signed Q4.14

  localparam logic signed [39:0] ACC_ONE = 40'sd67108864;    // 1.0 in Q.26
  localparam logic signed [39:0] ACC_LIM = 40'sd4294967296;  // accumulator clamp
  localparam logic [22:0] OUT_POS_MAX = 23'd131071;
  localparam logic [22:0] OUT_NEG_MAX = 23'd131072;

  // r(i) = round(2^32 / ((2i-1)(2i))), entry 0 unused
  localparam logic [R_W-1:0] RECIP_Q32 [32] = '{
    32'd0,          32'd2147483648, 32'd357913941,  32'd143165577,
    32'd76695845,   32'd47721859,   32'd32537631,   32'd23598721,
    32'd17895697,   32'd14035841,   32'd11302546,   32'd9296466,
    32'd7780738,    32'd6607642,    32'd5681174,    32'd4936744,
    32'd4329604,    32'd3827957,    32'd3408704,    32'd3054742,
    32'd2753184,    32'd2494174,    32'd2270067,    32'd2074863,
    32'd1903798,    32'd1753048,    32'd1619520,    32'd1500687,
    32'd1394470,    32'd1299143,    32'd1213268,    32'd1135634
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MUL_T,
    ST_MUL_P,
    ST_DRAIN,
    ST_ROUND
  } state_t;

  typedef enum logic [1:0] {
    OP_SQUARE,
    OP_SCALE,
    OP_TERM
  } mul_op_t;

  typedef struct packed {
    mul_op_t op;
    logic    first;     // first scale step: s comes straight off the product
    logic    acc_step;  // fold the pending product into the accumulator
    logic    out_load;  // write the result register
  } ctl_t;

endpackage

`default_nettype wire

// ----- hdl/cosine_series_eval_unit.sv -----
`default_nettype none

// Truncated cosine Maclaurin series, Horner form on x^2, one shared multiplier.
// A new angle is accepted only while the sequencer is idle: each word runs the
// square, two passes per term through the single multiplier (none when the
// clipped term count is 0) and the final rounding before the next is taken.
// Reset (rst, synchronous, active high): sequencer idle, no result pending,
// term_count back to 7.
module cosine_series_eval_unit #(
  parameter int MAX_TERMS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // angle input, signed Q3.13
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [15:0]                 angle,
  // result output
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [cse_pkg::OUT_W-1:0]        cosine,
  output logic                                    saturated,
  // term count register write
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [3:0]                         term_count
);
  import cse_pkg::*;

  localparam logic [IDX_W-1:0] N_MAX = IDX_W'(MAX_TERMS - 1);

  logic                     go;
  logic                     out_free;
  logic                     idle;
  ctl_t                     ctl;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         n_init;

  logic [3:0]               term_cnt;   // config register
  logic [X_W-1:0]           x_mag;      // |x|, the sign drops out of x^2
  logic [S_W-1:0]           s;
  logic [S_W-1:0]           s_op;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;

  logic signed [MA_W-1:0]   mul_a;
  logic [R_W-1:0]           mul_b;
  logic signed [PROD_W-1:0] prod;

  logic [62:0]              t_sum;
  logic [T_W-1:0]           t;

  logic                     p_neg;
  logic [PROD_W-1:0]        p_abs;
  logic [63:0]              p_rsum;
  logic [39:0]              p_rnd;
  logic signed [39:0]       acc_upd;

  logic                     a_neg;
  logic [ACC_W-1:0]         a_abs;
  logic [34:0]              f_sum;
  logic [22:0]              f_mag;
  logic                     f_sat;
  logic [OUT_W-1:0]         f_val;

  // ---------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------
  assign in_stall  = !idle;
  assign go        = in_valid && idle;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = idle;

  always_ff @(posedge clk) begin
    if (rst)
      term_cnt <= 4'd7;
    else if (cfg_valid && cfg_ready)
      term_cnt <= term_count;
  end

  // series index is limited to MAX_TERMS - 1
  assign n_init = ({1'b0, term_cnt} > N_MAX) ? N_MAX : IDX_W'(term_cnt);

  cse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .n_init   (n_init),
    .out_free (out_free),
    .ctl      (ctl),
    .idx      (idx),
    .idle     (idle)
  );

  // ---------------------------------------------------------------------
  // shared multiplier operand select
  //   square: |x| * |x|
  //   scale : s * r(i)
  //   term  : acc * t
  // ---------------------------------------------------------------------
  assign s_op = ctl.first ? prod[S_W-1:0] : s;

  always_comb begin
    case (ctl.op)
      OP_SQUARE: begin
        mul_a = MA_W'(x_mag);
        mul_b = R_W'(x_mag);
      end
      OP_SCALE: begin
        mul_a = MA_W'(s_op);
        mul_b = RECIP_Q32[idx];
      end
      OP_TERM: begin
        mul_a = MA_W'(acc);
        mul_b = R_W'(t);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  cse_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // t = (s * r + 2^31) >> 32
  assign t_sum = prod[62:0] + (63'd1 << 31);
  assign t     = t_sum[61:32];

  // acc = 1 - round(t * acc), rounding half away from zero, then clamp
  assign p_neg   = prod[PROD_W-1];
  assign p_abs   = p_neg ? ($unsigned(~prod) + PROD_W'(1)) : $unsigned(prod);
  assign p_rsum  = {1'b0, p_abs[62:0]} + (64'd1 << 25);
  assign p_rnd   = {2'b00, p_rsum[63:26]};
  assign acc_upd = p_neg ? (ACC_ONE + $signed(p_rnd)) : (ACC_ONE - $signed(p_rnd));

  always_comb begin
    if (acc_upd > ACC_LIM)
      acc_next = ACC_LIM[ACC_W-1:0];
    else if (acc_upd < -ACC_LIM)
      acc_next = ACC_W'(-ACC_LIM);
    else
      acc_next = acc_upd[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x_mag <= angle[15] ? X_W'(-angle) : X_W'(angle);
      acc   <= ACC_ONE[ACC_W-1:0];
    end else if (ctl.acc_step) begin
      acc <= acc_next;
    end
    if (ctl.first)
      s <= prod[S_W-1:0];
  end

  // ---------------------------------------------------------------------
  // final rounding to Q4.14 and saturation
  // ---------------------------------------------------------------------
  assign a_neg = acc[ACC_W-1];
  assign a_abs = a_neg ? ($unsigned(~acc) + ACC_W'(1)) : $unsigned(acc);
  assign f_sum = {1'b0, a_abs} + 35'd2048;
  assign f_mag = f_sum[34:12];
  assign f_sat = a_neg ? (f_mag > OUT_NEG_MAX) : (f_mag > OUT_POS_MAX);

  always_comb begin
    if (f_sat)
      f_val = a_neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    else if (a_neg)
      f_val = OUT_W'(~f_mag + 23'd1);
    else
      f_val = f_mag[OUT_W-1:0];
  end

  // result register: holds a word while the sink stalls
  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (ctl.out_load)
      out_valid <= 1'b1;
    else if (!out_stall)
      out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      cosine    <= $signed(f_val);
      saturated <= f_sat;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/cse_mul.sv -----
`default_nettype none

// Shared multiplier, product registered.
module cse_mul (
  input  wire logic                            clk,
  input  wire logic signed [cse_pkg::MA_W-1:0] a,
  input  wire logic        [cse_pkg::R_W-1:0]  b,
  output logic signed [cse_pkg::PROD_W-1:0]    prod
);
  import cse_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * $signed({1'b0, b});
  end

endmodule

`default_nettype wire

// ----- hdl/cse_ctrl.sv -----
`default_nettype none

// Sequencer: square, then two multiplier passes per series term.
module cse_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        go,
  input  wire logic [cse_pkg::IDX_W-1:0]   n_init,
  input  wire logic                        out_free,
  output cse_pkg::ctl_t                    ctl,
  output logic [cse_pkg::IDX_W-1:0]        idx,
  output logic                             idle
);
  import cse_pkg::*;

  state_t            state, state_next;
  logic              pend;   // a term product waits to be folded in
  logic [IDX_W-1:0]  idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (go)
        pend <= 1'b0;
      else if (state == ST_MUL_P)
        pend <= 1'b1;
    end
  end

  always_comb begin
    idx_next = idx;
    if (go)
      idx_next = n_init;
    else if (state == ST_MUL_P)
      idx_next = idx - IDX_W'(1);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (go) state_next = ST_SQUARE;
      ST_SQUARE: state_next = (idx == '0) ? ST_ROUND : ST_MUL_T;
      ST_MUL_T:  state_next = ST_MUL_P;
      ST_MUL_P:  state_next = (idx == IDX_W'(1)) ? ST_DRAIN : ST_MUL_T;
      ST_DRAIN:  state_next = ST_ROUND;
      ST_ROUND:  if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '{op: OP_SQUARE, first: 1'b0, acc_step: 1'b0, out_load: 1'b0};
    idle = 1'b0;
    case (state)
      ST_IDLE:   idle = 1'b1;
      ST_SQUARE: ctl.op = OP_SQUARE;
      ST_MUL_T: begin
        ctl.op       = OP_SCALE;
        ctl.first    = !pend;
        ctl.acc_step = pend;
      end
      ST_MUL_P:  ctl.op = OP_TERM;
      ST_DRAIN:  ctl.acc_step = 1'b1;
      ST_ROUND:  ctl.out_load = out_free;
      default:   idle = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- verif/cosine_series_eval_unit_tb.sv -----
`default_nettype none

module cosine_series_eval_unit_tb;

  import cse_pkg::*;

  localparam int MAX_TERMS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_PHASES = 8;
  localparam int PHASE_WORDS = 100;
  localparam int N_DIRECTED = 21;
  localparam longint ONE_Q26 = 64'sd1 <<< 26;
  localparam longint ACC_CLAMP = 64'sd1 <<< 32;
  localparam longint COS_MAX = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint COS_MIN = -(64'sd1 <<< (OUT_W - 1));

  // Predicts the series value of each accepted angle and holds the words
  // still owed by the block, oldest first.
  class cosine_checker;
    typedef struct {
      logic signed [OUT_W-1:0] cosine;
      logic                    saturated;
    } cos_word_t;

    int unsigned terms;
    cos_word_t   owed_words[$];
    int          failures;

    function new();
      terms = 7;
      failures = 0;
    endfunction

    function void set_terms(logic [3:0] v);
      terms = v;
    endfunction

    function int outstanding();
      return owed_words.size();
    endfunction

    // 1/((2i-1)(2i)) in Q0.32, rounded to nearest
    function longint unsigned recip_q32(int unsigned i);
      longint unsigned d;
      d = longint'(2 * i - 1) * longint'(2 * i);
      return ((64'd1 << 32) + d / 2) / d;
    endfunction

    // shift right with rounding, ties away from zero
    function longint round_away(longint v, int unsigned sh);
      longint unsigned mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      if (v < 0)
        return -mag;
      return mag;
    endfunction

    function void note_angle(logic signed [15:0] a);
      cos_word_t       w;
      longint          x;
      longint          acc;
      longint          p;
      longint          res;
      longint unsigned s;
      longint unsigned t;
      int              n;
      x = a;
      s = x * x;
      n = (terms > MAX_TERMS - 1) ? MAX_TERMS - 1 : terms;
      acc = ONE_Q26;
      // Horner on x^2, innermost term first
      for (int i = n; i >= 1; i--) begin
        t = (s * recip_q32(i) + (64'd1 << 31)) >> 32;
        p = longint'(t) * acc;
        acc = ONE_Q26 - round_away(p, 26);
        if (acc > ACC_CLAMP)
          acc = ACC_CLAMP;
        if (acc < -ACC_CLAMP)
          acc = -ACC_CLAMP;
      end
      res = round_away(acc, 12);
      w.saturated = 1'b0;
      if (res > COS_MAX) begin
        res = COS_MAX;
        w.saturated = 1'b1;
      end else if (res < COS_MIN) begin
        res = COS_MIN;
        w.saturated = 1'b1;
      end
      w.cosine = res[OUT_W-1:0];
      owed_words.push_back(w);
    endfunction

    function void check_result(logic signed [OUT_W-1:0] c, logic sat);
      cos_word_t w;
      if (owed_words.size() == 0) begin
        $error("unexpected result word: cosine %0d saturated %0d", c, sat);
        failures++;
        return;
      end
      w = owed_words.pop_front();
      if (c !== w.cosine) begin
        $error("cosine: expected %0d, got %0d", w.cosine, c);
        failures++;
      end
      if (sat !== w.saturated) begin
        $error("saturated: expected %0d, got %0d", w.saturated, sat);
        failures++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [15:0]      angle = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [OUT_W-1:0] cosine;
  logic                    saturated;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [3:0]              term_count = '0;

  cosine_checker chk;
  int            cycles = 0;
  int            burst_left = 0;

  // receiver stall pattern state
  int stall_mode = 0;
  int mode_left = 0;
  int run_left = 0;
  bit stall_lvl = 1'b0;

  // directed words: term count and angle (Q3.13)
  int dir_terms [N_DIRECTED] = '{7, 7, 7, 7, 7, 7,
                                 0, 0, 0,
                                 15, 15, 15, 15, 15, 15,
                                 1, 1, 1, 1,
                                 2, 2};
  int dir_angles [N_DIRECTED] = '{0, 32767, -32768, 8192, 12868, 25736,
                                  0, -32768, 32767,
                                  1, -1, -32768, 32767, 25736, -16384,
                                  -32768, 32767, 16384, -8192,
                                  -32768, 23170};

  cosine_series_eval_unit #(
    .MAX_TERMS(MAX_TERMS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .angle     (angle),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cosine    (cosine),
    .saturated (saturated),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .term_count(term_count)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: switches between free flow, scattered stalls and long stall runs.
  always @(posedge clk) begin
    bit nxt;
    nxt = 1'b0;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(32, 256);
    end
    mode_left--;
    case (stall_mode)
      1: nxt = ($urandom_range(0, 2) == 0);
      2: begin
        if (run_left == 0) begin
          stall_lvl = ~stall_lvl;
          run_left = $urandom_range(1, 12);
        end
        run_left--;
        nxt = stall_lvl;
      end
      default: nxt = 1'b0;
    endcase
    out_stall <= rst ? 1'b0 : nxt;
  end

  // Accepted words on both channels, sampled at the edge that moves them.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        chk.note_angle(angle);
      if (out_valid && !out_stall)
        chk.check_result(cosine, saturated);
    end
  end

  task automatic send_angle(input logic signed [15:0] a);
    in_valid <= 1'b1;
    angle <= a;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  // Sender bursts: after each word, maybe end the burst and leave a gap.
  task automatic pace();
    int gap;
    if (burst_left > 0)
      burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
  endtask

  // Stop sending and wait until every owed word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk.outstanding() > 0)
      @(posedge clk);
  endtask

  task automatic write_terms(input logic [3:0] v);
    cfg_valid <= 1'b1;
    term_count <= v;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    chk.set_terms(v);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_angle();
    int v;
    case ($urandom_range(0, 9))
      5, 6: v = $urandom_range(0, 4095) - 2048;
      7: begin
        // around +/- pi
        v = 25736 + $urandom_range(0, 400) - 200;
        if ($urandom_range(0, 1) == 1)
          v = -v;
      end
      8: v = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3)
                                  : -32768 + $urandom_range(0, 3);
      9: v = $urandom_range(0, 15) - 8;
      default: v = $urandom_range(0, 65535);
    endcase
    return v[15:0];
  endfunction

  initial begin
    int n;
    chk = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: first group runs on the reset term count
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (i > 0 && dir_terms[i] != dir_terms[i-1]) begin
        drain();
        write_terms(dir_terms[i][3:0]);
      end
      send_angle(dir_angles[i][15:0]);
      pace();
    end

    // random phases, term count changed only while idle
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: n = 15;
        1: n = 0;
        2: n = 7;
        default: n = $urandom_range(0, 15);
      endcase
      drain();
      write_terms(n[3:0]);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        send_angle(pick_angle());
        pace();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (chk.failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

// ----- cosine_series_eval_unit.f -----
hdl/cse_pkg.sv
hdl/cse_mul.sv
hdl/cse_ctrl.sv
hdl/cosine_series_eval_unit.sv
verif/cosine_series_eval_unit_tb.sv
